// File: rtl/tfme_pkg.sv
// Shared constants, types and frame-building functions for the temperature frame encoder.
package tfme_pkg;

  localparam int TEMP_W     = 13;
  localparam int RAW_W      = 12;
  localparam int PAT_W      = 16;
  localparam int IDX_W      = 5;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;
  localparam int SEQ_W      = 50;
  localparam int MSG_BITS   = 40;
  localparam int FRAME_W    = 192;
  localparam int FRAME_BYTES = FRAME_W / 8;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);

  localparam logic [CFG_IDX_W-1:0] CFG_STATION_ID = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL    = CFG_IDX_W'(1);

  localparam logic [7:0] STATION_ID_RST = 8'h00;
  localparam logic [7:0] CHANNEL_RST    = 8'h01;

  localparam logic [7:0]  MODEL_BYTE    = 8'h46;
  localparam logic [7:0]  HUMIDITY_BYTE = 8'd50;
  localparam logic [7:0]  DIGEST_GEN    = 8'h98;
  localparam logic [7:0]  DIGEST_KEY    = 8'h3E;
  localparam logic [7:0]  DIGEST_XOR    = 8'h64;
  localparam logic [11:0] PREAMBLE_HEAD = 12'h001;
  localparam logic [14:0] PREAMBLE_REP  = 15'h1FFD;
  localparam logic signed [16:0] RAW_BIAS = 17'sd720;
  localparam logic signed [16:0] RAW_MAX  = 17'sd4095;

  typedef logic [7:0] key_tab_t [MSG_BITS];

  // The digest key sequence does not depend on the data, so it is a constant table.
  function automatic key_tab_t gen_keys();
    key_tab_t   tab;
    logic [7:0] k;
    k = DIGEST_KEY;
    for (int j = 0; j < MSG_BITS; j++) begin
      tab[j] = k;
      k = k[0] ? ((k >> 1) ^ DIGEST_GEN) : (k >> 1);
    end
    return tab;
  endfunction

  localparam key_tab_t DIGEST_KEYS = gen_keys();

  function automatic logic [7:0] digest8(input logic [MSG_BITS-1:0] msg);
    logic [7:0] acc;
    acc = 8'h00;
    for (int j = 0; j < MSG_BITS; j++) begin
      if (msg[MSG_BITS-1-j]) begin
        acc = acc ^ DIGEST_KEYS[j];
      end
    end
    return acc;
  endfunction

  // q*9/8 truncated toward zero, biased and saturated to the 12-bit code range.
  function automatic logic [RAW_W-1:0] to_raw(input logic signed [TEMP_W-1:0] q);
    logic signed [16:0] ext;
    logic signed [16:0] prod;
    logic signed [16:0] adj;
    logic signed [16:0] biased;
    logic [RAW_W-1:0]   res;
    ext    = 17'(q);
    prod   = (ext <<< 3) + ext;
    adj    = prod + (prod[16] ? 17'sd7 : 17'sd0);
    biased = (adj >>> 3) + RAW_BIAS;
    if (biased < 17'sd0) begin
      res = '0;
    end else if (biased > RAW_MAX) begin
      res = '1;
    end else begin
      res = biased[RAW_W-1:0];
    end
    return res;
  endfunction

  function automatic logic [3:0] chan_nibble(input logic [7:0] setting);
    logic [3:0] nib;
    if (setting == 8'd0) begin
      nib = 4'd0;
    end else if (setting > 8'd8) begin
      nib = 4'd7;
    end else begin
      nib = 4'(setting - 8'd1);
    end
    return nib;
  endfunction

  function automatic logic [PAT_W-1:0] manchester(input logic [7:0] b);
    logic [PAT_W-1:0] pat;
    for (int i = 0; i < 8; i++) begin
      pat[2*i +: 2] = b[i] ? 2'b10 : 2'b01;
    end
    return pat;
  endfunction

endpackage

// File: rtl/temperature_frame_manchester_encoder.sv
// A temperature passes the input register, the serializer's frame register and the output register.
// One Manchester byte per cycle on the result port while out_ready is high;
// the next temperature is accepted while the current frame is still being sent.
// Reset: synchronous, active low; clears all valid flags and the byte counter,
// sets the station ID to 0 and channel_setting to 1.
module temperature_frame_manchester_encoder import tfme_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [TEMP_W-1:0] in_temperature_q4,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [PAT_W-1:0]         out_manchester_pattern,
  output logic [IDX_W-1:0]         out_byte_index,
  output logic                     out_last,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  logic [7:0]         station_id_r;
  logic [7:0]         channel_setting_r;
  logic               frm_valid;
  logic               frm_ready;
  logic [FRAME_W-1:0] frame;

  assign cfg_ready = 1'b1;

  // Writes to an unknown index are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      station_id_r      <= STATION_ID_RST;
      channel_setting_r <= CHANNEL_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_STATION_ID) begin
        station_id_r <= cfg_data;
      end else if (cfg_index == CFG_CHANNEL) begin
        channel_setting_r <= cfg_data;
      end
    end
  end

  tfme_frame_build u_build (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_temperature_q4 (in_temperature_q4),
    .station_id        (station_id_r),
    .channel_setting   (channel_setting_r),
    .frm_valid         (frm_valid),
    .frm_ready         (frm_ready),
    .frame             (frame)
  );

  tfme_serializer u_ser (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .frm_valid              (frm_valid),
    .frm_ready              (frm_ready),
    .frame                  (frame),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_manchester_pattern (out_manchester_pattern),
    .out_byte_index         (out_byte_index),
    .out_last               (out_last)
  );

  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_byte_index == LAST_IDX)
    else $error("last flag on a byte other than the final one");

  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=>
      out_valid && out_byte_index == IDX_W'($past(out_byte_index) + IDX_W'(1)))
    else $error("frame bytes not delivered back to back in order");

  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(out_valid) |-> $past(out_last))
    else $error("output went idle in the middle of a frame");

endmodule

// File: rtl/tfme_frame_build.sv
// Input register and combinational assembly of the 192-bit frame.
module tfme_frame_build import tfme_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [TEMP_W-1:0] in_temperature_q4,
  input  logic [7:0]               station_id,
  input  logic [7:0]               channel_setting,
  output logic                     frm_valid,
  input  logic                     frm_ready,
  output logic [FRAME_W-1:0]       frame
);

  logic                     valid_r;
  logic signed [TEMP_W-1:0] temp_r;
  logic [RAW_W-1:0]         raw;
  logic [7:0]               s2;
  logic [7:0]               s3;
  logic [7:0]               s5;
  logic [SEQ_W-1:0]         seq;

  assign in_ready  = !valid_r || frm_ready;
  assign frm_valid = valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (frm_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      temp_r <= in_temperature_q4;
    end
  end

  always_comb begin
    raw   = to_raw(temp_r);
    s2    = {chan_nibble(channel_setting), raw[11:8]};
    s3    = raw[7:0];
    s5    = digest8({MODEL_BYTE, station_id, s2, s3, HUMIDITY_BYTE}) ^ DIGEST_XOR;
    seq   = {MODEL_BYTE, station_id, s2, s3, HUMIDITY_BYTE, s5, 2'b00};
    frame = {PREAMBLE_HEAD, seq, PREAMBLE_REP, seq, PREAMBLE_REP, seq};
  end

endmodule

// File: rtl/tfme_serializer.sv
// Frame shift register, byte counter and Manchester-coded output register.
module tfme_serializer import tfme_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               frm_valid,
  output logic               frm_ready,
  input  logic [FRAME_W-1:0] frame,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [PAT_W-1:0]   out_manchester_pattern,
  output logic [IDX_W-1:0]   out_byte_index,
  output logic               out_last
);

  logic               busy_r;
  logic [IDX_W-1:0]   cnt_r;
  logic               out_valid_r;
  logic [FRAME_W-1:0] frame_r;
  logic [PAT_W-1:0]   pattern_r;
  logic [IDX_W-1:0]   idx_r;
  logic               last_r;
  logic               adv;
  logic               final_byte;

  // The output register moves whenever it is empty or its transaction completes.
  assign adv        = !out_valid_r || out_ready;
  assign final_byte = busy_r && (cnt_r == LAST_IDX);
  assign frm_ready  = !busy_r || (adv && final_byte);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_r <= busy_r;
      end
      if (frm_valid && frm_ready) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (adv && busy_r) begin
        cnt_r <= cnt_r + IDX_W'(1);
        if (final_byte) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && busy_r) begin
      pattern_r <= manchester(frame_r[FRAME_W-1 -: 8]);
      idx_r     <= cnt_r;
      last_r    <= (cnt_r == LAST_IDX);
    end
    if (frm_valid && frm_ready) begin
      frame_r <= frame;
    end else if (adv && busy_r) begin
      frame_r <= frame_r << 8;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_manchester_pattern = pattern_r;
  assign out_byte_index         = idx_r;
  assign out_last               = last_r;

endmodule

// File: tb/tb.sv
// Self-checking testbench for the temperature frame Manchester encoder.
module tb;
  import tfme_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 3000;
  localparam int SETTLE_CYCLES = 8;
  localparam int BATCH        = 20;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_CHANNEL + 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP   = '1;

  typedef struct {
    logic [PAT_W-1:0] pattern;
    logic [IDX_W-1:0] index;
    logic             last;
  } frame_byte_t;

  class frame_scoreboard;
    localparam logic [7:0]  MODEL_ID      = 8'h46;
    localparam logic [7:0]  HUMIDITY      = 8'd50;
    localparam logic [7:0]  DIG_GEN       = 8'h98;
    localparam logic [7:0]  DIG_KEY       = 8'h3E;
    localparam logic [7:0]  DIG_XOR       = 8'h64;
    localparam logic [11:0] HEAD_PREAMBLE = 12'h001;
    localparam logic [14:0] REP_PREAMBLE  = 15'h1FFD;
    localparam int          CODE_OFFSET   = 720;
    localparam int          CODE_MAX      = 4095;

    logic [7:0]  station_id;
    logic [7:0]  channel_setting;
    frame_byte_t expected_bytes[$];
    int          errors;
    int          bytes_checked;

    function new();
      station_id      = 8'h00;
      channel_setting = 8'h01;
      errors          = 0;
      bytes_checked   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_STATION_ID) begin
        station_id = val;
      end else if (idx == CFG_CHANNEL) begin
        channel_setting = val;
      end
    endfunction

    function logic [11:0] temp_code(logic signed [TEMP_W-1:0] t);
      int scaled;
      // Integer division truncates toward zero, as the scaling requires.
      scaled = (int'(t) * 9) / 8 + CODE_OFFSET;
      if (scaled < 0) scaled = 0;
      if (scaled > CODE_MAX) scaled = CODE_MAX;
      return scaled[11:0];
    endfunction

    function logic [7:0] lfsr_digest(logic [39:0] msg);
      logic [7:0] acc;
      logic [7:0] k;
      acc = 8'h00;
      k   = DIG_KEY;
      for (int i = 39; i >= 0; i--) begin
        if (msg[i]) acc = acc ^ k;
        k = k[0] ? ((k >> 1) ^ DIG_GEN) : (k >> 1);
      end
      return acc;
    endfunction

    function logic [PAT_W-1:0] manchester_of(logic [7:0] b);
      logic [PAT_W-1:0] pat;
      pat = '0;
      for (int i = 7; i >= 0; i--) begin
        pat = {pat[PAT_W-3:0], (b[i] ? 2'b10 : 2'b01)};
      end
      return pat;
    endfunction

    function void note_temp(logic signed [TEMP_W-1:0] t);
      logic [3:0]   nib;
      logic [39:0]  msg;
      logic [49:0]  seq;
      logic [191:0] frame;
      frame_byte_t  fb;
      if (channel_setting == 8'd0) begin
        nib = 4'd0;
      end else if (channel_setting > 8'd8) begin
        nib = 4'd7;
      end else begin
        nib = 4'(channel_setting - 8'd1);
      end
      msg   = {MODEL_ID, station_id, nib, temp_code(t), HUMIDITY};
      seq   = {msg, lfsr_digest(msg) ^ DIG_XOR, 2'b00};
      frame = {HEAD_PREAMBLE, seq, REP_PREAMBLE, seq, REP_PREAMBLE, seq};
      for (int k = 0; k < 24; k++) begin
        fb.pattern = manchester_of(frame[191-8*k -: 8]);
        fb.index   = IDX_W'(k);
        fb.last    = (k == 23);
        expected_bytes.push_back(fb);
      end
    endfunction

    function void check_byte(logic [PAT_W-1:0] pattern, logic [IDX_W-1:0] index, logic last);
      frame_byte_t exp_b;
      if (expected_bytes.size() == 0) begin
        $error("unexpected frame byte: pattern %h index %0d last %b", pattern, index, last);
        errors++;
        return;
      end
      exp_b = expected_bytes.pop_front();
      bytes_checked++;
      if (pattern !== exp_b.pattern) begin
        $error("manchester_pattern: expected %h, got %h", exp_b.pattern, pattern);
        errors++;
      end
      if (index !== exp_b.index) begin
        $error("byte_index: expected %0d, got %0d", exp_b.index, index);
        errors++;
      end
      if (last !== exp_b.last) begin
        $error("last: expected %b, got %b", exp_b.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic signed [TEMP_W-1:0] in_temperature_q4;
  logic                     out_valid;
  logic                     out_ready;
  logic [PAT_W-1:0]         out_manchester_pattern;
  logic [IDX_W-1:0]         out_byte_index;
  logic                     out_last;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_data;

  frame_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_pending  = 1'b0;
  int holds_done    = 0;
  int temps_taken   = 0;
  int writes_taken  = 0;
  int quiet_cycles  = 0;

  temperature_frame_manchester_encoder u_top (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_temperature_q4      (in_temperature_q4),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_manchester_pattern (out_manchester_pattern),
    .out_byte_index         (out_byte_index),
    .out_last               (out_last),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data)
  );

  always #2 clk = ~clk;

  // Every transaction is observed here, on pre-edge values.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        sb.write_reg(cfg_index, cfg_data);
        writes_taken++;
      end
      if (in_valid && in_ready) begin
        sb.note_temp(in_temperature_q4);
        temps_taken++;
      end
      if (out_valid && out_ready) begin
        sb.check_byte(out_manchester_pattern, out_byte_index, out_last);
      end
      if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  initial begin : rx_side
    int held;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        out_ready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
        hold_pending = 1'b0;
        holds_done++;
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_temp(input int t);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid          <= 1'b1;
    in_temperature_q4 <= TEMP_W'(t);
    do @(posedge clk); while (!in_ready);
  endtask

  // Leaves cfg_valid high so that back-to-back writes need no gap.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Drops in_valid and lets the monitor note the last accepted temperature before waiting for the drain.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_regs();
    logic [7:0] ch;
    case ($urandom_range(9))
      0:       ch = 8'd0;
      1, 2:    ch = 8'($urandom_range(9, 255));
      default: ch = 8'($urandom_range(1, 8));
    endcase
    if ($urandom_range(3) == 0) begin
      cfg_write(CFG_IDX_W'($urandom_range(int'(CFG_SPARE), int'(CFG_TOP))), 8'($urandom));
    end
    cfg_write(CFG_STATION_ID, 8'($urandom));
    cfg_write(CFG_CHANNEL, ch);
    cfg_valid <= 1'b0;
  endtask

  // Mostly codes inside the linear range, with clamp boundaries and raw noise mixed in.
  function automatic int pick_temp();
    int sel;
    sel = $urandom_range(9);
    if (sel < 6) return int'($urandom_range(3640)) - 640;
    if (sel < 8) return int'(signed'(TEMP_W'($urandom)));
    if (sel == 8) return int'($urandom_range(20)) - 650;
    return int'($urandom_range(20)) + 2990;
  endfunction

  initial begin
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_temperature_q4 = '0;
    cfg_valid         = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 28;
    recv_idle_pct = 58;

    // Registers still at their reset values.
    send_temp(0);
    send_temp(4095);
    settle();
    // Channel zero, and writes to unknown indexes that must change nothing.
    cfg_write(CFG_STATION_ID, 8'hFF);
    cfg_write(CFG_CHANNEL, 8'h00);
    cfg_write(CFG_SPARE, 8'h55);
    cfg_write(CFG_TOP, 8'hAA);
    cfg_valid <= 1'b0;
    send_temp(-4096);
    send_temp(-1);
    send_temp(-640);
    send_temp(-641);
    settle();
    cfg_write(CFG_STATION_ID, 8'hA5);
    cfg_write(CFG_CHANNEL, 8'd8);
    cfg_valid <= 1'b0;
    send_temp(1);
    send_temp(-7);
    send_temp(3000);
    send_temp(3001);
    settle();
    // Channel settings above eight saturate the nibble.
    cfg_write(CFG_STATION_ID, 8'h00);
    cfg_write(CFG_CHANNEL, 8'd9);
    cfg_valid <= 1'b0;
    send_temp(-4095);
    send_temp(4094);
    send_temp(16);
    settle();
    cfg_write(CFG_CHANNEL, 8'hFF);
    cfg_valid <= 1'b0;
    send_temp(-2731);
    send_temp(1365);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 28; recv_idle_pct = 58; end
        1: begin send_idle_pct = 58; recv_idle_pct = 28; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int b = 0; b < 3; b++) begin
        settle();
        random_regs();
        for (int i = 0; i < BATCH; i++) begin
          // One long receiver stall while temperatures keep coming.
          if (ph == 0 && b == 0 && i == 5) hold_pending = 1'b1;
          send_temp(pick_temp());
        end
      end
    end

    settle();
    $display("tb: %0d temperatures, %0d frame bytes checked, %0d register writes",
             temps_taken, sb.bytes_checked, writes_taken);
    $display("tb: covered clamping, channel saturation, ignored indexes, %0d long stall(s)",
             holds_done);
    if (sb.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/tfme_pkg.sv
rtl/tfme_frame_build.sv
rtl/tfme_serializer.sv
rtl/temperature_frame_manchester_encoder.sv
tb/tb.sv
